>>> sv/wpcd_pkg.sv
// Package for the weather packet check and decode block.
// Holds sequencer states, message type and reading kind codes, and widths.
// No dependencies.
`default_nettype none

package wpcd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CRC_BYTES = 6;
  localparam int unsigned CRC_BITS  = CRC_BYTES * BYTE_W;
  localparam int unsigned CRC_CNT_W = $clog2(CRC_BITS);
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam int unsigned RAW_W      = 10;
  localparam int unsigned DIV_W      = 16;
  localparam int unsigned DVS_W      = RAW_W;
  localparam int unsigned DIR_W      = 9;
  localparam int unsigned VAL_W      = 17;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned RAIN_W     = 7;
  localparam int unsigned PROD_W     = 31;
  localparam int unsigned DIR_PROD_W = 26;

  localparam logic [DIR_W-1:0]  HALF_TURN  = 9'd180;
  // floor(b2 * 24 / 17) equals (b2 * 185064) >> 17 for every byte value
  localparam logic [17:0]       DIR_MUL    = 18'd185064;
  localparam logic [20:0]       SOLAR_MUL  = 21'd1757936;
  localparam logic [PROD_W-1:0] SOLAR_DIV  = 31'd100000000;
  localparam logic [DIV_W-1:0]  RATE_FAST  = 16'd57600;
  localparam logic [DIV_W-1:0]  RATE_SLOW  = 16'd3600;

  localparam logic [3:0] MSG_SUPERCAP = 4'h2;
  localparam logic [3:0] MSG_RAINRATE = 4'h5;
  localparam logic [3:0] MSG_SOLAR    = 4'h7;
  localparam logic [3:0] MSG_TEMP     = 4'h8;
  localparam logic [3:0] MSG_GUST     = 4'h9;
  localparam logic [3:0] MSG_HUMIDITY = 4'hA;
  localparam logic [3:0] MSG_RAINCNT  = 4'hE;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_SUPERCAP = 3'd1;
  localparam logic [2:0] KIND_RAINRATE = 3'd2;
  localparam logic [2:0] KIND_SOLAR    = 3'd3;
  localparam logic [2:0] KIND_TEMP     = 3'd4;
  localparam logic [2:0] KIND_GUST     = 3'd5;
  localparam logic [2:0] KIND_HUMIDITY = 3'd6;
  localparam logic [2:0] KIND_RAINCNT  = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CRC   = 5'b00010,
    S_RATE  = 5'b00100,
    S_SOLAR = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

>>> sv/weather_packet_check_decode_unit.sv
// Top level of the weather packet check and decode block.
// Bit-serial CRC-16 check, decode sequencer, rain total. Uses wpcd_pkg, wpcd_div.
`default_nettype none

// One packet of eight bytes is taken per transfer on the input channel and
// gives exactly one result transfer. The CRC-16 (0x1021, init 0) is checked
// one bit per cycle over bytes 0..5; the wind direction comes from a
// reciprocal multiply at the end of the check. Rain rate packets with a
// nonzero raw rate then run the radix-2 divider (16 quotient bits), and
// solar packets subtract 100000000 from the scaled reading once per cycle
// while it is at least 100000000. The result is loaded in S_OUT as soon as
// no earlier result still waits under output stall; input stall is high
// from the transfer until the load, so the next packet can be taken in the
// cycle after the load. A finished result waits in the output register
// while the next packet is taken. require_crc_ok (reset 1) is written
// through cfg_we_i/cfg_wdata_i; the user must write it only while the
// block is idle, not enforced by the block. With it set, a failing packet
// gives zeroed decode fields, crc_ok 0, and leaves the rain total untouched.
module weather_packet_check_decode_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  pkt_byte0_i,
  input  wire logic [7:0]  pkt_byte1_i,
  input  wire logic [7:0]  pkt_byte2_i,
  input  wire logic [7:0]  pkt_byte3_i,
  input  wire logic [7:0]  pkt_byte4_i,
  input  wire logic [7:0]  pkt_byte5_i,
  input  wire logic [7:0]  crc_sent_high_i,
  input  wire logic [7:0]  crc_sent_low_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             crc_ok_o,
  output logic [3:0]       message_type_o,
  output logic             battery_low_o,
  output logic [7:0]       wind_speed_mph_o,
  output logic [8:0]       wind_direction_deg_o,
  output logic [2:0]       reading_kind_o,
  output logic signed [16:0] reading_value_o,
  output logic [31:0]      rain_clicks_total_o
);
  import wpcd_pkg::*;

  state_e state_q, state_d;
  logic [CRC_CNT_W-1:0] cnt_q, cnt_d;
  logic                 req_q;
  logic                 out_valid_q, out_valid_d;

  logic [7:0]           b0_q, b1_q, b3_q, b4_q;
  logic [7:0]           dir_byte_q;
  logic [CRC_W-1:0]     sent_q;
  logic [CRC_BITS-1:0]  sh_q, sh_d;
  logic [CRC_W-1:0]     crc_q, crc_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [DIR_W-1:0]     dir_q, dir_d;
  logic [VAL_W-1:0]     val_q, val_d;

  logic [RAIN_W-1:0]    last_q, last_d;
  logic                 seen_q, seen_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  logic                 in_xfer, load;
  logic                 fb;
  logic                 div_start, div_done;
  logic [DIV_W-1:0]     div_dividend, quotient;
  logic [DVS_W-1:0]     div_divisor;
  logic [RAW_W-1:0]     rate_raw, raw_in;
  logic [DIR_PROD_W-1:0] dir_prod;
  logic [DIR_W-1:0]     dir_raw;
  logic                 crc_ok, decode_en;
  logic [2:0]           kind;
  logic [VAL_W-1:0]     value;
  logic [RAIN_W-1:0]    cur, fwd;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // solar raw reading from the input bytes, scaled at transfer
  assign raw_in     = {pkt_byte3_i, pkt_byte4_i[7:6]};
  assign rate_raw   = {b4_q[5:4], b3_q};

  assign fb = crc_q[CRC_W-1] ^ sh_q[CRC_BITS-1];

  // floor(b2 * 360 / 255) by reciprocal multiply
  assign dir_prod = DIR_PROD_W'(dir_byte_q) * DIR_PROD_W'(DIR_MUL);
  assign dir_raw  = dir_prod[DIR_PROD_W-1 -: DIR_W];

  wpcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    sh_d         = sh_q;
    crc_d        = crc_q;
    prod_d       = prod_q;
    dir_d        = dir_q;
    val_d        = val_q;
    div_start    = 1'b0;
    div_dividend = b4_q[6] ? RATE_SLOW : RATE_FAST;
    div_divisor  = rate_raw;
    load         = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          sh_d    = {pkt_byte0_i, pkt_byte1_i, pkt_byte2_i,
                     pkt_byte3_i, pkt_byte4_i, pkt_byte5_i};
          crc_d   = '0;
          cnt_d   = '0;
          prod_d  = PROD_W'(raw_in) * PROD_W'(SOLAR_MUL);
          state_d = S_CRC;
        end
      end
      S_CRC: begin
        crc_d = {crc_q[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        sh_d  = {sh_q[CRC_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CRC_CNT_W'(CRC_BITS - 1)) begin
          dir_d = (dir_raw >= HALF_TURN) ? dir_raw - HALF_TURN : dir_raw + HALF_TURN;
          val_d = '0;
          if (b0_q[7:4] == MSG_SOLAR) begin
            state_d = S_SOLAR;
          end else if ((b0_q[7:4] == MSG_RAINRATE) && (rate_raw != '0)) begin
            div_start = 1'b1;
            state_d   = S_RATE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_RATE: begin
        if (div_done) begin
          val_d   = VAL_W'(quotient);
          state_d = S_OUT;
        end
      end
      S_SOLAR: begin
        if (prod_q >= SOLAR_DIV) begin
          prod_d = prod_q - SOLAR_DIV;
          val_d  = val_q + 1'b1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign crc_ok    = (crc_q == sent_q);
  assign decode_en = crc_ok || !req_q;

  always_comb begin
    kind  = KIND_NONE;
    value = '0;
    case (b0_q[7:4])
      MSG_SUPERCAP: begin
        kind  = KIND_SUPERCAP;
        value = VAL_W'({b3_q, b4_q[7:6]});
      end
      MSG_RAINRATE: begin
        kind  = KIND_RAINRATE;
        value = (rate_raw == '0) ? '0 : val_q;
      end
      MSG_SOLAR: begin
        kind  = KIND_SOLAR;
        value = val_q;
      end
      MSG_TEMP: begin
        kind  = KIND_TEMP;
        value = {b3_q[7], b3_q, b4_q};
      end
      MSG_GUST: begin
        kind  = KIND_GUST;
        value = VAL_W'(b3_q);
      end
      MSG_HUMIDITY: begin
        kind  = KIND_HUMIDITY;
        value = VAL_W'({b4_q[7:4], b3_q});
      end
      MSG_RAINCNT: begin
        kind  = KIND_RAINCNT;
        value = VAL_W'(b3_q[6:0]);
      end
      default: begin
        kind  = KIND_NONE;
        value = '0;
      end
    endcase
  end

  assign cur = b3_q[RAIN_W-1:0];
  assign fwd = cur - last_q;

  always_comb begin
    last_d  = last_q;
    seen_d  = seen_q;
    total_d = total_q;
    if (load && decode_en && (b0_q[7:4] == MSG_RAINCNT)) begin
      if (seen_q && !fwd[RAIN_W-1]) begin
        total_d = total_q + TOTAL_W'(fwd);
      end
      last_d = cur;
      seen_d = 1'b1;
    end
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      req_q       <= 1'b1;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      seen_q      <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      seen_q      <= seen_d;
      total_q     <= total_d;
      if (cfg_we_i) begin
        req_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    crc_q  <= crc_d;
    prod_q <= prod_d;
    dir_q  <= dir_d;
    val_q  <= val_d;
    if (in_xfer) begin
      b0_q       <= pkt_byte0_i;
      b1_q       <= pkt_byte1_i;
      dir_byte_q <= pkt_byte2_i;
      b3_q       <= pkt_byte3_i;
      b4_q       <= pkt_byte4_i;
      sent_q     <= {crc_sent_high_i, crc_sent_low_i};
    end
    if (load) begin
      crc_ok_o             <= crc_ok;
      message_type_o       <= decode_en ? b0_q[7:4] : '0;
      battery_low_o        <= decode_en ? b0_q[3] : 1'b0;
      wind_speed_mph_o     <= decode_en ? b1_q : '0;
      wind_direction_deg_o <= decode_en ? dir_q : '0;
      reading_kind_o       <= decode_en ? kind : KIND_NONE;
      reading_value_o      <= decode_en ? value : '0;
      rain_clicks_total_o  <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/wpcd_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Used for the rain rate decode. Uses wpcd_pkg.
`default_nettype none

module wpcd_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [wpcd_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [wpcd_pkg::DVS_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [wpcd_pkg::DIV_W-1:0]      quotient_o
);
  import wpcd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DIV_W-1:0]    quo_q, quo_d;
  logic [DVS_W-1:0]    rem_q, rem_d;
  logic [DVS_W-1:0]    dvs_q, dvs_d;
  logic [DVS_W:0]      trial;
  logic                ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
